FILE: rtl/lrupr_pkg.sv
package lrupr_pkg;

    localparam int PAGE_W  = 8;
    localparam int SLOT_W  = 4;
    localparam int FAULT_W = 16;
    localparam int CFG_W   = 5;

    localparam logic [FAULT_W-1:0] FAULT_MAX   = '1;
    localparam logic [CFG_W-1:0]   CFG_RESET   = 5'd16;
    localparam logic [CFG_W-1:0]   CFG_LIMIT_0 = 5'd0;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic              last_reference;
    } t_in_item;

    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic               evicted_valid;
        logic [PAGE_W-1:0]  evicted_page;
        logic [FAULT_W-1:0] fault_total;
    } t_out_item;

    // broadcast strobes shared by every cell of the row
    typedef struct packed {
        logic look;     // capture match flags against the incoming page
        logic upd;      // apply the update decided for the captured item
        logic age_all;  // new frame: every resident frame ages by one
        logic clear;    // end of reference string: drop all frames
    } t_cell_ctrl;

    // per-cell status returned to the top level
    typedef struct packed {
        logic valid;    // frame is resident
        logic hit;      // resident page equals the captured page
        logic lru;      // frame holds the oldest rank
        logic free;     // first non-resident frame of the row
    } t_cell_flags;

endpackage

FILE: rtl/lrupr_cell.sv
module lrupr_cell
    import lrupr_pkg::*;
#(
    parameter int RW = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctrl            i_ctrl,
    input  logic                  i_sel,
    input  logic                  i_prev_valid,
    input  logic [PAGE_W-1:0]     i_look_page,
    input  logic [RW-1:0]         i_lru_rank,
    input  logic [RW-1:0]         i_old_rank,
    input  logic [PAGE_W-1:0]     i_new_page,
    output t_cell_flags           o_flags,
    output logic [RW-1:0]         o_rank,
    output logic [PAGE_W-1:0]     o_page
);

    logic              r_valid;
    logic              r_hit;
    logic              r_lru;
    logic [RW-1:0]     r_rank;
    logic [PAGE_W-1:0] r_page;

    // valid bits form a thermometer along the row: the first free frame
    // is the one whose left neighbor is resident
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
            r_lru   <= 1'b0;
        end else begin
            if (i_ctrl.look) begin
                r_hit <= r_valid && (r_page == i_look_page);
                r_lru <= r_valid && (r_rank == i_lru_rank);
            end
            if (i_ctrl.upd) begin
                if (i_ctrl.clear) begin
                    r_valid <= 1'b0;
                end else if (i_sel) begin
                    r_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.upd && !i_ctrl.clear) begin
            if (i_sel) begin
                r_page <= i_new_page;
                r_rank <= '0;
            end else if (r_valid && (i_ctrl.age_all || (r_rank < i_old_rank))) begin
                r_rank <= r_rank + RW'(1);
            end
        end
    end

    assign o_flags.valid = r_valid;
    assign o_flags.hit   = r_hit;
    assign o_flags.lru   = r_lru;
    assign o_flags.free  = !r_valid && i_prev_valid;
    assign o_rank        = r_rank;
    assign o_page        = r_page;

endmodule

FILE: rtl/lru_page_replacement.sv
// Channel   Direction  Handshake                  Payload
// in        to block   i_in_valid / o_in_stall    i_in_item  (page, last_reference)
// out       from block o_out_valid / i_out_stall  o_out_item (hit, slot, evicted, faults)
// cfg       to block   i_cfg_we                   i_cfg_data (frames_in_use)
//
// For each item, the accept edge captures the page and lets every frame cell
// compare it and flag a hit or the oldest rank; a later commit edge applies
// hit, fill or replacement to the row and loads the output register.
// The row of frame cells is busy for the whole item, which sets the rate.
// A stalled output register holds the update until the result can be loaded.
// Synchronous active-low reset empties all frames, clears the fault count
// and sets the frame limit to 16; no clearing pass is needed.
module lru_page_replacement
    import lrupr_pkg::*;
#(
    parameter int FRAMES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_item,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int RW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int FW = $clog2(FRAMES + 1);
    localparam int LW = (FW > CFG_W) ? FW : CFG_W;

    logic             r_busy;
    t_in_item         r_item;
    logic [CFG_W-1:0] r_limit;
    logic [FW-1:0]    r_filled;
    logic [FAULT_W-1:0] r_faults;
    logic             r_out_valid;
    t_out_item        r_out_item;

    logic [FAULT_W-1:0] n_faults;
    logic [FW-1:0]      n_filled;
    t_out_item          n_out_item;

    logic accept;
    logic out_free;
    logic commit;

    t_cell_ctrl     ctrl;
    t_cell_flags    flags [FRAMES];
    logic [RW-1:0]  ranks [FRAMES];
    logic [PAGE_W-1:0] pages [FRAMES];
    logic [FRAMES-1:0] prev_valid;
    logic [FRAMES-1:0] valid_vec;
    logic [FRAMES-1:0] hit_vec;
    logic [FRAMES-1:0] lru_vec;
    logic [FRAMES-1:0] free_vec;
    logic [FRAMES-1:0] sel_vec;

    logic              hit_any;
    logic [RW-1:0]     hit_rank;
    logic [PAGE_W-1:0] lru_page;
    logic [SLOT_W-1:0] slot;
    logic [FW-1:0]     filled_m1;
    logic [RW-1:0]     lru_rank;
    logic [RW-1:0]     old_rank;
    logic [LW-1:0]     limit;
    logic              do_fill;
    logic              do_replace;

    // one item in flight: hold off the source until the row is updated
    assign accept   = i_in_valid && !r_busy;
    assign out_free = !r_out_valid || !i_out_stall;
    assign commit   = r_busy && out_free;

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // clamp the frame limit into 1..FRAMES
    always_comb begin
        if (r_limit == CFG_LIMIT_0) begin
            limit = LW'(1);
        end else if (LW'(r_limit) > LW'(FRAMES)) begin
            limit = LW'(FRAMES);
        end else begin
            limit = LW'(r_limit);
        end
    end

    // the oldest resident frame carries rank filled-1: ranks are a permutation
    assign filled_m1 = r_filled - FW'(1);
    assign lru_rank  = filled_m1[RW-1:0];

    // gather the flags of the row; at most one cell hits, at most one is oldest
    always_comb begin
        hit_rank = '0;
        lru_page = '0;
        for (int i = 0; i < FRAMES; i++) begin
            valid_vec[i] = flags[i].valid;
            hit_vec[i]   = flags[i].hit;
            lru_vec[i]   = flags[i].lru;
            free_vec[i]  = flags[i].free;
            hit_rank     = hit_rank | (flags[i].hit ? ranks[i] : '0);
            lru_page     = lru_page | (flags[i].lru ? pages[i] : '0);
        end
    end

    assign hit_any    = |hit_vec;
    assign do_fill    = !hit_any && (LW'(r_filled) < limit);
    assign do_replace = !hit_any && !do_fill;
    assign old_rank   = hit_any ? hit_rank : lru_rank;

    // pick the target frame: hit frame, else next free frame, else the oldest
    always_comb begin
        slot = '0;
        for (int i = 0; i < FRAMES; i++) begin
            sel_vec[i] = hit_any ? hit_vec[i] : (do_fill ? free_vec[i] : lru_vec[i]);
            slot       = slot | (sel_vec[i] ? SLOT_W'(i) : '0);
        end
    end

    always_comb begin
        if (hit_any || (r_faults == FAULT_MAX)) begin
            n_faults = r_faults;
        end else begin
            n_faults = r_faults + FAULT_W'(1);
        end
        n_filled = r_filled + FW'(do_fill);

        n_out_item.hit           = hit_any;
        n_out_item.slot          = slot;
        n_out_item.evicted_valid = do_replace;
        n_out_item.evicted_page  = do_replace ? lru_page : '0;
        n_out_item.fault_total   = n_faults;
    end

    assign ctrl.look    = accept;
    assign ctrl.upd     = commit;
    assign ctrl.age_all = do_fill;
    assign ctrl.clear   = r_item.last_reference;

    assign prev_valid[0] = 1'b1;
    for (genvar g = 1; g < FRAMES; g++) begin : g_link
        assign prev_valid[g] = flags[g-1].valid;
    end

    for (genvar g = 0; g < FRAMES; g++) begin : g_row
        lrupr_cell #(
            .RW (RW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (ctrl),
            .i_sel        (sel_vec[g]),
            .i_prev_valid (prev_valid[g]),
            .i_look_page  (i_in_item.page),
            .i_lru_rank   (lru_rank),
            .i_old_rank   (old_rank),
            .i_new_page   (r_item.page),
            .o_flags      (flags[g]),
            .o_rank       (ranks[g]),
            .o_page       (pages[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_limit     <= CFG_RESET;
            r_filled    <= '0;
            r_faults    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (accept) begin
                r_busy <= 1'b1;
            end else if (commit) begin
                r_busy <= 1'b0;
            end
            if (commit) begin
                r_out_valid <= 1'b1;
                // drop the run after the last reference has its result
                if (r_item.last_reference) begin
                    r_filled <= '0;
                    r_faults <= '0;
                end else begin
                    r_filled <= n_filled;
                    r_faults <= n_faults;
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in_item;
        end
        if (commit) begin
            r_out_item <= n_out_item;
        end
    end

    a_single_hit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> $onehot0(hit_vec))
        else $error("more than one frame holds the referenced page");

    a_one_victim : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && do_replace) |-> $onehot(lru_vec))
        else $error("replacement without a unique oldest frame");

    a_fill_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(valid_vec) == int'(r_filled))
        else $error("resident frames disagree with fill count");

    a_fill_target : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && do_fill) |-> $onehot(free_vec))
        else $error("fill without a unique free frame");

    a_run_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit && r_item.last_reference) |=> (r_filled == '0 && r_faults == '0))
        else $error("run not cleared after last reference");

endmodule
